FILE: src/vbf_pkg.sv
package vbf_pkg;

  // default bitmap depth in 32-bit words
  localparam int unsigned MAP_WORDS_DEFAULT = 2048;

  // saturation point of the fresh counter
  localparam logic [16:0] COUNT_MAX = 17'd65536;

  // map word width and bit index width
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_IDX_W = 5;

  // configuration register indexes
  localparam logic CFG_CLEAR_ON_START = 1'b0;
  localparam logic CFG_WORDS_IN_USE   = 1'b1;

  // item kinds
  typedef enum logic [1:0] {
    KIND_TEST  = 2'd0,
    KIND_MARK  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_START = 2'd3
  } kind_e;

  // clear sequencer states
  typedef enum logic {
    CLR_IDLE  = 1'b0,
    CLR_SWEEP = 1'b1
  } clr_state_e;

endpackage

FILE: src/visited_bitmap_filter.sv
// Visited bitmap with test-and-set.
// Input stream s_axis: tuser carries the item kind (test, mark, close group,
// start batch), tdata[30:0] the node index. Output stream m_axis: one result
// transfer per input transfer, in order. tuser[0] = fresh, tuser[1] = out of
// range, tdata[30:0] = node echo (zero unless a test), tdata[47:31] = running fresh count.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 clear_on_start, 1 map_words_in_use); write only while idle.
// A result passes the RAM stage registers, then the output register.
// Throughput: one item per cycle while neither a stall nor a sweep holds the
// input; each item is one read of the map RAM and one write back as it leaves
// the RAM stage, with a forwarding register covering back-to-back hits on the
// same word.
// Reset: the map RAM is swept to zero, one word per cycle, with s_axis_tready
// low. A start batch with clear_on_start set triggers the same sweep after it.
// Stall: when m_axis_tready is low the result waits in the output register,
// one more item waits in the RAM stage, and then s_axis_tready drops.
module visited_bitmap_filter #(
  parameter int unsigned MAP_WORDS = vbf_pkg::MAP_WORDS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [11:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] node, [31] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [30:0] node_out, [47:31] group_split
  output logic [1:0]  m_axis_tuser    // [0] fresh, [1] out_of_range
);

  localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned LW = $clog2(MAP_WORDS + 1);
  localparam int unsigned WB = vbf_pkg::WORD_BITS;

  // configuration registers
  logic          clear_on_start_q;
  logic [11:0]   words_in_use_q;
  logic [LW-1:0] words_lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_on_start_q <= 1'b0;
      words_in_use_q   <= 12'd2048;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vbf_pkg::CFG_CLEAR_ON_START: clear_on_start_q <= cfg_data_i[0];
        vbf_pkg::CFG_WORDS_IN_USE:   words_in_use_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // words in use, capped at the map depth
  assign words_lim = (32'(words_in_use_q) > 32'(MAP_WORDS)) ? LW'(MAP_WORDS)
                                                          : LW'(words_in_use_q);

  // input decode
  vbf_pkg::kind_e in_kind;
  logic [30:0]    in_node;
  logic           in_is_node;
  logic           in_oor;
  logic           in_acc;

  assign in_kind    = vbf_pkg::kind_e'(s_axis_tuser);
  assign in_node    = s_axis_tdata[30:0];
  assign in_is_node = (in_kind == vbf_pkg::KIND_TEST) || (in_kind == vbf_pkg::KIND_MARK);
  assign in_oor     = in_is_node &&
                      (32'(in_node[30:vbf_pkg::BIT_IDX_W]) >= 32'(words_lim));
  assign in_acc     = s_axis_tvalid && s_axis_tready;

  // RAM stage registers
  logic           s1_valid_q;
  vbf_pkg::kind_e s1_kind_q;
  logic [30:0]    s1_node_q;
  logic           s1_oor_q;
  logic           s1_adv;

  // clear sequencer
  logic          clr_start;
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  vbf_clear #(
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_clear (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (clr_start),
    .busy_o  (clr_busy),
    .addr_o  (clr_addr)
  );

  // output register
  logic        out_valid_q;
  logic        out_fresh_q;
  logic        out_oor_q;
  logic [30:0] out_node_q;
  logic [16:0] out_split_q;

  assign s1_adv = s1_valid_q && (!out_valid_q || m_axis_tready);

  // hold off while sweeping and behind a start batch that will sweep
  assign s_axis_tready = !clr_busy && (!s1_valid_q || s1_adv) &&
                         !(s1_valid_q && (s1_kind_q == vbf_pkg::KIND_START) &&
                           clear_on_start_q);

  assign clr_start = s1_adv && (s1_kind_q == vbf_pkg::KIND_START) && clear_on_start_q;

  // map RAM
  logic [WB-1:0] ram_rdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WB-1:0] ram_wdata;
  logic          item_we;
  logic [AW-1:0] s1_addr;
  logic [WB-1:0] new_word;

  assign s1_addr = s1_node_q[vbf_pkg::BIT_IDX_W +: AW];

  vbf_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (in_acc && in_is_node),
    .raddr_i (in_node[vbf_pkg::BIT_IDX_W +: AW]),
    .rdata_o (ram_rdata),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata)
  );

  assign ram_we    = clr_busy || item_we;
  assign ram_waddr = clr_busy ? clr_addr : s1_addr;
  assign ram_wdata = clr_busy ? '0 : new_word;

  // forwarding of the last item write
  logic          fwd_valid_q;
  logic [AW-1:0] fwd_addr_q;
  logic [WB-1:0] fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (clr_start) begin
      fwd_valid_q <= 1'b0;
    end else if (item_we) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_we) begin
      fwd_addr_q <= s1_addr;
      fwd_data_q <= new_word;
    end
  end

  // test and set
  logic [WB-1:0] cur_word;
  logic [WB-1:0] bit_mask;
  logic          s1_is_node;
  logic          was_set;
  logic          s1_fresh;
  logic [16:0]   count_q, count_d;

  assign s1_is_node = (s1_kind_q == vbf_pkg::KIND_TEST) || (s1_kind_q == vbf_pkg::KIND_MARK);
  assign cur_word   = (fwd_valid_q && (fwd_addr_q == s1_addr)) ? fwd_data_q : ram_rdata;
  assign bit_mask   = WB'(1) << s1_node_q[vbf_pkg::BIT_IDX_W-1:0];
  assign was_set    = |(cur_word & bit_mask);
  assign new_word   = cur_word | bit_mask;
  assign item_we    = s1_adv && s1_is_node && !s1_oor_q;
  assign s1_fresh   = (s1_kind_q == vbf_pkg::KIND_TEST) && !s1_oor_q && !was_set;

  // running fresh count
  always_comb begin
    count_d = count_q;
    case (s1_kind_q)
      vbf_pkg::KIND_TEST: begin
        if (s1_fresh && (count_q < vbf_pkg::COUNT_MAX)) count_d = count_q + 17'd1;
      end
      vbf_pkg::KIND_START: count_d = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (s1_adv) begin
      count_q <= count_d;
    end
  end

  // RAM stage control and payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q <= in_kind;
      s1_node_q <= in_node;
      s1_oor_q  <= in_oor;
    end
  end

  // output register control and payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_fresh_q <= s1_fresh;
      out_oor_q   <= s1_oor_q;
      out_node_q  <= (s1_kind_q == vbf_pkg::KIND_TEST) ? s1_node_q : '0;
      out_split_q <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_split_q, out_node_q};
  assign m_axis_tuser  = {out_oor_q, out_fresh_q};

  // no item in the RAM stage while the map is swept
  a_no_item_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !s1_valid_q && !item_we)
    else $error("item in flight during map sweep");

  // a sweep request only comes from a start batch leaving the RAM stage
  a_sweep_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_start |=> clr_busy && !s_axis_tready)
    else $error("sweep did not start after start batch");

  // fresh results are never out of range
  a_fresh_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_fresh_q |-> !out_oor_q)
    else $error("fresh result flagged out of range");

  // count never exceeds its saturation point
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= vbf_pkg::COUNT_MAX)
    else $error("fresh count above limit");

  // a stalled result keeps the next item parked in the RAM stage
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !m_axis_tready |=> s1_valid_q && out_valid_q)
    else $error("item lost under output stall");

endmodule

FILE: src/vbf_ram.sv
module vbf_ram #(
  parameter int unsigned DEPTH = vbf_pkg::MAP_WORDS_DEFAULT,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                           clk_i,
  input  logic                           re_i,
  input  logic [AW-1:0]                  raddr_i,
  output logic [vbf_pkg::WORD_BITS-1:0]  rdata_o,
  input  logic                           we_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic [vbf_pkg::WORD_BITS-1:0]  wdata_i
);

  logic [vbf_pkg::WORD_BITS-1:0] mem [DEPTH];
  logic [vbf_pkg::WORD_BITS-1:0] rdata_q;

  // registered read, old data on a same-cycle write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/vbf_clear.sv
module vbf_clear #(
  parameter int unsigned DEPTH = vbf_pkg::MAP_WORDS_DEFAULT,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output logic [AW-1:0] addr_o
);

  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

  vbf_pkg::clr_state_e state_q, state_d;
  logic [AW-1:0]       ptr_q, ptr_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vbf_pkg::CLR_IDLE: begin
        if (start_i) state_d = vbf_pkg::CLR_SWEEP;
      end
      vbf_pkg::CLR_SWEEP: begin
        if (ptr_q == LastAddr) state_d = vbf_pkg::CLR_IDLE;
      end
      default: state_d = vbf_pkg::CLR_IDLE;
    endcase
  end

  // outputs and sweep pointer
  always_comb begin
    busy_o = 1'b0;
    ptr_d  = ptr_q;
    unique case (state_q)
      vbf_pkg::CLR_IDLE: begin
        ptr_d = '0;
      end
      vbf_pkg::CLR_SWEEP: begin
        busy_o = 1'b1;
        ptr_d  = (ptr_q == LastAddr) ? '0 : ptr_q + AW'(1);
      end
      default: begin
        ptr_d = '0;
      end
    endcase
  end

  assign addr_o = ptr_q;

  // the map holds garbage after reset, so a sweep starts at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vbf_pkg::CLR_SWEEP;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // watchdog limit: cycles with no transfer on either side
  localparam int unsigned STALL_LIMIT = 20000;
  // length of the long receiver hold-off
  localparam int unsigned HOLD_CYCLES = 300;
  // cap on printed mismatch lines
  localparam int unsigned MAX_REPORTS = 50;
  // length of the run of fresh nodes in one batch
  localparam int unsigned RUN_NODES = 64;

  // one result transfer, fields as they leave the block
  typedef struct packed {
    logic        fresh;
    logic [30:0] node_out;
    logic [16:0] split;
    logic        oor;
  } visit_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [11:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [30:0] node, [31] zero
  logic [1:0]  s_axis_tuser = '0;   // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [30:0] node_out, [47:31] group_split
  logic [1:0]  m_axis_tuser;        // [0] fresh, [1] out_of_range

  // shadow of the block state
  logic [31:0] visited_map [vbf_pkg::MAP_WORDS_DEFAULT];
  logic [16:0] fresh_count;
  logic        clear_cfg;
  logic [11:0] words_cfg;

  visit_result_t pending_results[$];
  int unsigned   error_count = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   items_sent = 0;
  int unsigned   hold_reqs = 0;
  int unsigned   hold_seen = 0;
  int unsigned   hold_left = 0;
  int unsigned   stall_cycles = 0;

  visited_bitmap_filter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // number of valid node indexes under the current setting
  function automatic int unsigned node_span();
    int unsigned words;
    words = (words_cfg > vbf_pkg::MAP_WORDS_DEFAULT) ? vbf_pkg::MAP_WORDS_DEFAULT
                                                     : int'(words_cfg);
    return words * vbf_pkg::WORD_BITS;
  endfunction

  // test-and-set on the shadow map, returns the result the item causes
  function automatic visit_result_t visit_node(vbf_pkg::kind_e kind, logic [30:0] node);
    visit_result_t r;
    int unsigned   word_idx;
    logic [31:0]   bit_mask;
    logic          was_set;
    r = '0;
    case (kind) inside
      vbf_pkg::KIND_TEST, vbf_pkg::KIND_MARK: begin
        if (node >= node_span()) begin
          r.oor = 1'b1;
        end else begin
          word_idx = node[30:vbf_pkg::BIT_IDX_W];
          bit_mask = 32'd1 << node[vbf_pkg::BIT_IDX_W-1:0];
          was_set  = |(visited_map[word_idx] & bit_mask);
          visited_map[word_idx] |= bit_mask;
          if (kind == vbf_pkg::KIND_TEST && !was_set) begin
            r.fresh = 1'b1;
            if (fresh_count < vbf_pkg::COUNT_MAX) fresh_count++;
          end
        end
        if (kind == vbf_pkg::KIND_TEST) r.node_out = node;
      end
      vbf_pkg::KIND_START: begin
        if (clear_cfg) foreach (visited_map[i]) visited_map[i] = '0;
        fresh_count = '0;
      end
      default: ;
    endcase
    r.split = fresh_count;
    return r;
  endfunction

  // node picker: mostly in range, some repeats, some near the edge, some anywhere
  function automatic logic [30:0] pick_node();
    int unsigned span;
    logic [31:0] raw;
    span = node_span();
    raw  = $urandom;
    case ($urandom_range(0, 9)) inside
      [0:3]:   return (span > 0) ? 31'($urandom_range(0, span - 1))
                                 : 31'($urandom_range(0, 63));
      [4:5]:   return 31'($urandom_range(0, 95));
      6:       return (span >= 4) ? 31'(span - 4 + $urandom_range(0, 7))
                                  : 31'($urandom_range(0, 7));
      [7:8]:   return raw[30:0];
      default: return 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
    endcase
  endfunction

  // offer one item and wait for its transfer
  task automatic send_item(input vbf_pkg::kind_e kind, input logic [30:0] node);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, node};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.insert(pending_results.size(), visit_node(kind, node));
    items_sent++;
  endtask

  // stop offering, let every result drain and any map sweep finish
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [11:0] data);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == vbf_pkg::CFG_CLEAR_ON_START) clear_cfg = data[0];
    else words_cfg = data;
  endtask

  // one well-formed batch: start, a few groups of tests and marks, each closed
  task automatic send_batch();
    int unsigned groups;
    int unsigned len;
    send_item(vbf_pkg::KIND_START, 31'($urandom));
    groups = $urandom_range(1, 4);
    repeat (groups) begin
      len = $urandom_range(1, 12);
      repeat (len) send_item(($urandom_range(0, 9) < 7) ? vbf_pkg::KIND_TEST
                                                         : vbf_pkg::KIND_MARK, pick_node());
      send_item(vbf_pkg::KIND_CLOSE, 31'($urandom));
    end
  endtask

  // extremes of the node field, repeats, marks, group close and batch start
  task automatic test_directed_basics();
    send_idle_pct = 20;
    recv_idle_pct = 88;
    send_item(vbf_pkg::KIND_TEST, 31'd0);
    send_item(vbf_pkg::KIND_TEST, 31'd0);
    send_item(vbf_pkg::KIND_MARK, 31'd5);
    send_item(vbf_pkg::KIND_TEST, 31'd5);
    send_item(vbf_pkg::KIND_TEST, 31'd65535);
    send_item(vbf_pkg::KIND_TEST, 31'd65536);
    send_item(vbf_pkg::KIND_TEST, 31'h7FFF_FFFF);
    send_item(vbf_pkg::KIND_MARK, 31'h7FFF_FFFF);
    send_item(vbf_pkg::KIND_CLOSE, 31'h7FFF_FFFF);
    send_item(vbf_pkg::KIND_START, 31'h5555_5555);
    send_item(vbf_pkg::KIND_TEST, 31'd0);
    send_item(vbf_pkg::KIND_TEST, 31'd33);
    send_item(vbf_pkg::KIND_CLOSE, 31'd0);
  endtask

  // words in use at zero, one, above the map size and at the map size
  task automatic test_word_limits();
    write_reg(vbf_pkg::CFG_WORDS_IN_USE, 12'd0);
    send_item(vbf_pkg::KIND_TEST, 31'd0);
    send_item(vbf_pkg::KIND_MARK, 31'd1);
    write_reg(vbf_pkg::CFG_WORDS_IN_USE, 12'd1);
    send_item(vbf_pkg::KIND_TEST, 31'd31);
    send_item(vbf_pkg::KIND_TEST, 31'd32);
    write_reg(vbf_pkg::CFG_WORDS_IN_USE, 12'hFFF);
    send_item(vbf_pkg::KIND_MARK, 31'd65534);
    send_item(vbf_pkg::KIND_TEST, 31'd65534);
    send_item(vbf_pkg::KIND_TEST, 31'd65536);
    write_reg(vbf_pkg::CFG_WORDS_IN_USE, 12'd2048);
    send_item(vbf_pkg::KIND_CLOSE, 31'd0);
  endtask

  // batch start with map clear, then previously visited nodes are fresh again
  task automatic test_clear_on_start();
    write_reg(vbf_pkg::CFG_CLEAR_ON_START, 12'hFFF);
    send_item(vbf_pkg::KIND_START, 31'd0);
    send_item(vbf_pkg::KIND_TEST, 31'd0);
    send_item(vbf_pkg::KIND_TEST, 31'd65535);
    send_item(vbf_pkg::KIND_CLOSE, 31'd0);
    write_reg(vbf_pkg::CFG_CLEAR_ON_START, 12'hFFE);
  endtask

  // a long run of fresh nodes in one batch, then a repeat that does not count
  task automatic test_count_run();
    write_reg(vbf_pkg::CFG_CLEAR_ON_START, 12'd1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item(vbf_pkg::KIND_START, 31'd0);
    for (int unsigned n = 0; n < RUN_NODES; n++) send_item(vbf_pkg::KIND_TEST, 31'(n));
    send_item(vbf_pkg::KIND_TEST, 31'd0);
    send_item(vbf_pkg::KIND_CLOSE, 31'd0);
    send_item(vbf_pkg::KIND_START, 31'd0);
    write_reg(vbf_pkg::CFG_CLEAR_ON_START, 12'd0);
  endtask

  // long receiver hold-off while items keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_idle();
    hold_reqs++;
    repeat (40) send_item(vbf_pkg::KIND_TEST, 31'($urandom_range(0, 127)));
    send_item(vbf_pkg::KIND_CLOSE, 31'd0);
  endtask

  // mostly well-formed batches with random content, some noise items
  task automatic test_random_traffic(input int unsigned count, input int unsigned send_pct,
                                     input int unsigned recv_pct);
    int unsigned stop_at;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 3) != 0) begin
        send_batch();
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(vbf_pkg::kind_e'($urandom_range(0, 3)), 31'($urandom));
      end
    end
  endtask

  // shadow reset
  initial begin
    foreach (visited_map[i]) visited_map[i] = '0;
    fresh_count = '0;
    clear_cfg   = 1'b0;
    words_cfg   = 12'd2048;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen     <= hold_reqs;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    visit_result_t got;
    visit_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.fresh    = m_axis_tuser[0];
      got.oor      = m_axis_tuser[1];
      got.node_out = m_axis_tdata[30:0];
      got.split    = m_axis_tdata[47:31];
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            if (got.fresh != want.fresh)
              $display("%0t: fresh expected %0d actual %0d", $time, want.fresh, got.fresh);
            if (got.node_out != want.node_out)
              $display("%0t: node_out expected %0d actual %0d", $time, want.node_out,
                       got.node_out);
            if (got.split != want.split)
              $display("%0t: group_split expected %0d actual %0d", $time, want.split,
                       got.split);
            if (got.oor != want.oor)
              $display("%0t: out_of_range expected %0d actual %0d", $time, want.oor,
                       got.oor);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // test sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_basics();
    test_word_limits();
    test_clear_on_start();
    test_count_run();
    test_backpressure();
    write_reg(vbf_pkg::CFG_WORDS_IN_USE, 12'd2048);
    test_random_traffic(190, 20, 88);
    write_reg(vbf_pkg::CFG_WORDS_IN_USE, 12'd3);
    write_reg(vbf_pkg::CFG_CLEAR_ON_START, 12'd1);
    test_random_traffic(180, 88, 20);
    write_reg(vbf_pkg::CFG_WORDS_IN_USE, 12'd100);
    write_reg(vbf_pkg::CFG_CLEAR_ON_START, 12'd0);
    test_random_traffic(180, 0, 0);
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
